// ===== rtl/core/aabb_pkg.sv =====
// Shared types, codes and helper functions for the rectangle collision table.
// Used by the controller, the datapath and the top level; no dependencies.
package aabb_pkg;

    localparam int NUM_MASKS   = 8;
    localparam int MASK_W      = 8;
    localparam int SLOT_FW     = 5;
    localparam int KIND_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;

    // Operation codes carried in the action field
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_ERASE = 3'd1;
    localparam logic [2:0] ACT_PURGE = 3'd2;
    localparam logic [2:0] ACT_SWEEP = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_ADDED = 2'd1,
        RES_FULL  = 2'd2,
        RES_HIT   = 2'd3
    } res_status_t;

    // Per-type receive masks, element j-1 belongs to type j
    typedef logic [NUM_MASKS-1:0][MASK_W-1:0] mask_bank_t;

    localparam mask_bank_t MASK_RESET = {8'd0, 8'd21, 8'd205, 8'd141,
                                         8'd2, 8'd2, 8'd205, 8'd2};

    // One stored table entry
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [KIND_W-1:0]  kind;
        logic               notify;
    } rect_rec_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_BASE,
        CS_CMP,
        CS_HIT2,
        CS_END
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec_op;
        logic read_base;
        logic load_base;
        logic step;
        logic emit_ik;
        logic emit_ki;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_sweep;
        logic sweep_ok;
        logic k_last;
        logic hit_ik;
        logic hit_ki;
        logic out_free;
        logic can_push;
    } dp_stat_t;

    // Receiver of type kr (notify nr) takes hits from type ko
    function automatic logic receives(mask_bank_t masks, logic [KIND_W-1:0] kr,
                                      logic nr, logic [KIND_W-1:0] ko);
        logic [2:0] ri;
        logic [2:0] oi;
        logic       res;
        ri  = 3'(kr - 4'd1);
        oi  = 3'(ko - 4'd1);
        res = nr && (kr >= 4'd1) && (kr <= 4'd8) && (ko >= 4'd1) && (ko <= 4'd8)
              && masks[ri][oi];
        return res;
    endfunction

    // Strict overlap of two rectangles, edges summed 17 bits wide
    function automatic logic overlap(rect_rec_t a, rect_rec_t b);
        logic signed [16:0] ax;
        logic signed [16:0] ay;
        logic signed [16:0] bx;
        logic signed [16:0] by;
        logic signed [16:0] axw;
        logic signed [16:0] ayh;
        logic signed [16:0] bxw;
        logic signed [16:0] byh;
        ax  = {a.x[15], a.x};
        ay  = {a.y[15], a.y};
        bx  = {b.x[15], b.x};
        by  = {b.y[15], b.y};
        axw = ax + {2'b00, a.w};
        ayh = ay + {2'b00, a.h};
        bxw = bx + {2'b00, b.w};
        byh = by + {2'b00, b.h};
        return (ax < bxw) && (axw > bx) && (ay < byh) && (ayh > by);
    endfunction

endpackage

// ===== rtl/core/aabb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
module aabb_ram #(
    parameter int WIDTH = 67,
    parameter int DEPTH = 32
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic                      re,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/aabb_ctrl.sv =====
// Controller state machine for the collision table: sequences each operation
// and the slot-by-slot sweep. Depends on aabb_pkg.
module aabb_ctrl
    import aabb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        advance;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (stat.is_sweep && stat.sweep_ok) begin
                    cmd.read_base = 1'b1;
                    state_next    = CS_BASE;
                end else if (stat.out_free) begin
                    cmd.exec_op = 1'b1;
                    state_next  = CS_IDLE;
                end
            end
            CS_BASE: begin
                cmd.load_base = 1'b1;
                if (stat.k_last) begin
                    state_next = CS_END;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = CS_CMP;
                end
            end
            CS_CMP: begin
                if (stat.hit_ik) begin
                    if (stat.can_push) begin
                        cmd.emit_ik = 1'b1;
                        if (stat.hit_ki) begin
                            state_next = CS_HIT2;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                end else if (stat.hit_ki) begin
                    if (stat.can_push) begin
                        cmd.emit_ki = 1'b1;
                        advance     = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
            end
            CS_HIT2: begin
                if (stat.can_push) begin
                    cmd.emit_ki = 1'b1;
                    advance     = 1'b1;
                end
            end
            CS_END: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase

        // Move to the next slot, or close the sweep after the top slot
        if (advance) begin
            if (stat.k_last) begin
                state_next = CS_END;
            end else begin
                cmd.step   = 1'b1;
                state_next = CS_CMP;
            end
        end
    end

endmodule

// ===== rtl/core/aabb_dpath.sv =====
// Datapath for the collision table: slot flags, rectangle RAM, mask
// registers, sweep compare, pending hit and output register.
// Depends on aabb_pkg and aabb_ram.
module aabb_dpath
    import aabb_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tlast,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [MASK_W-1:0]       cfg_wdata,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat
);

    localparam int SW = $clog2(SLOTS);

    // Command registers
    logic [2:0]         act_reg;
    logic [SLOT_FW-1:0] slot_reg;
    rect_rec_t          rec_in_reg;

    // Table state
    logic [SLOTS-1:0]   occ_reg;
    logic [SLOTS-1:0]   doomed_reg;
    mask_bank_t         masks_reg;

    // Sweep state
    rect_rec_t          base_reg;
    logic [SW-1:0]      k_reg;
    logic [SW-1:0]      k_next;
    rect_rec_t          rd_rec;

    // Pending hit, held back until the next one shows whether it is the last
    logic               pend_valid_reg;
    logic [SLOT_FW-1:0] pend_rcv_reg;
    logic [SLOT_FW-1:0] pend_oth_reg;

    // Output register
    logic               out_valid_reg;
    res_status_t        out_status_reg;
    logic [SLOT_FW-1:0] out_rcv_reg;
    logic [SLOT_FW-1:0] out_oth_reg;
    logic               out_last_reg;

    logic               push;
    res_status_t        push_status;
    logic [SLOT_FW-1:0] push_rcv;
    logic [SLOT_FW-1:0] push_oth;
    logic               push_last;

    logic               slot_ok;
    logic [SW-1:0]      slot_idx;
    logic               free_found;
    logic [SW-1:0]      free_idx;
    logic               out_free;
    logic               ram_we;
    logic               ram_re;
    logic [SW-1:0]      ram_raddr;
    logic [SLOT_FW-1:0] new_rcv;
    logic [SLOT_FW-1:0] new_oth;

    assign slot_ok  = ({1'b0, slot_reg} < (SLOT_FW + 1)'(SLOTS));
    assign slot_idx = slot_reg[SW-1:0];
    assign k_next   = SW'(k_reg + 1'b1);
    assign out_free = !out_valid_reg || m_tready;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // Latch the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            act_reg           <= s_tdata[2:0];
            slot_reg          <= s_tdata[7:3];
            rec_in_reg.x      <= s_tdata[23:8];
            rec_in_reg.y      <= s_tdata[39:24];
            rec_in_reg.w      <= s_tdata[54:40];
            rec_in_reg.h      <= s_tdata[69:55];
            rec_in_reg.kind   <= s_tdata[73:70];
            rec_in_reg.notify <= s_tdata[74];
        end
    end

    // Receive masks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            masks_reg <= MASK_RESET;
        end else if (cfg_wr_en) begin
            masks_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Occupied and doomed flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            doomed_reg <= '0;
        end else if (cmd.exec_op) begin
            case (act_reg)
                ACT_ADD: begin
                    if (free_found) begin
                        occ_reg[free_idx]    <= 1'b1;
                        doomed_reg[free_idx] <= 1'b0;
                    end
                end
                ACT_ERASE: begin
                    if (slot_ok && occ_reg[slot_idx]) begin
                        doomed_reg[slot_idx] <= 1'b1;
                    end
                end
                ACT_PURGE: begin
                    occ_reg    <= occ_reg & ~doomed_reg;
                    doomed_reg <= '0;
                end
                ACT_CLEAR: begin
                    occ_reg    <= '0;
                    doomed_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Rectangle store
    assign ram_we    = cmd.exec_op && (act_reg == ACT_ADD) && free_found;
    assign ram_re    = cmd.read_base || cmd.step;
    assign ram_raddr = cmd.read_base ? slot_idx : k_next;

    aabb_ram #(
        .WIDTH ($bits(rect_rec_t)),
        .DEPTH (SLOTS)
    ) u_rect_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (rec_in_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_rec)
    );

    // Sweep index and base rectangle
    always_ff @(posedge aclk) begin
        if (cmd.read_base) begin
            k_reg <= slot_idx;
        end else if (cmd.step) begin
            k_reg <= k_next;
        end
        if (cmd.load_base) begin
            base_reg <= rd_rec;
        end
    end

    // Status to the controller
    always_comb begin
        stat.is_sweep = (act_reg == ACT_SWEEP);
        stat.sweep_ok = slot_ok && occ_reg[slot_idx];
        stat.k_last   = (k_reg == SW'(SLOTS - 1));
        stat.hit_ik   = occ_reg[k_reg] && overlap(base_reg, rd_rec) &&
                        receives(masks_reg, base_reg.kind, base_reg.notify, rd_rec.kind);
        stat.hit_ki   = occ_reg[k_reg] && overlap(base_reg, rd_rec) &&
                        receives(masks_reg, rd_rec.kind, rd_rec.notify, base_reg.kind);
        stat.out_free = out_free;
        stat.can_push = !pend_valid_reg || out_free;
    end

    // New hit pair for the pending register
    assign new_rcv = cmd.emit_ik ? slot_reg : SLOT_FW'(k_reg);
    assign new_oth = cmd.emit_ik ? SLOT_FW'(k_reg) : slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.latch || cmd.finish) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.emit_ik || cmd.emit_ki) begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_ik || cmd.emit_ki) begin
            pend_rcv_reg <= new_rcv;
            pend_oth_reg <= new_oth;
        end
    end

    // Select the beat to load into the output register
    always_comb begin
        push        = 1'b0;
        push_status = RES_DONE;
        push_rcv    = '0;
        push_oth    = '0;
        push_last   = 1'b0;
        if (cmd.exec_op) begin
            push      = 1'b1;
            push_last = 1'b1;
            if (act_reg == ACT_ADD) begin
                if (free_found) begin
                    push_status = RES_ADDED;
                    push_rcv    = SLOT_FW'(free_idx);
                end else begin
                    push_status = RES_FULL;
                end
            end
        end else if ((cmd.emit_ik || cmd.emit_ki) && pend_valid_reg) begin
            push        = 1'b1;
            push_status = RES_HIT;
            push_rcv    = pend_rcv_reg;
            push_oth    = pend_oth_reg;
        end else if (cmd.finish) begin
            push      = 1'b1;
            push_last = 1'b1;
            if (pend_valid_reg) begin
                push_status = RES_HIT;
                push_rcv    = pend_rcv_reg;
                push_oth    = pend_oth_reg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_status_reg <= push_status;
            out_rcv_reg    <= push_rcv;
            out_oth_reg    <= push_oth;
            out_last_reg   <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_oth_reg, out_rcv_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    // A doomed slot is always an occupied one
    a_doomed_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (doomed_reg & ~occ_reg) == '0)
        else $error("doomed flag set on a free slot");

    // Single results and the closing beat only load a free output register
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec_op || cmd.finish) |-> out_free)
        else $error("result loaded over an untaken beat");

    // A hit is only taken when the pending pair can move on
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_ik || cmd.emit_ki) |-> (!pend_valid_reg || out_free))
        else $error("hit pair emitted with no room");

    // The sweep index never steps past the top slot
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (k_reg != SW'(SLOTS - 1)))
        else $error("sweep stepped past the last slot");

endmodule

// ===== rtl/core/aabb_collision_table.sv =====
// Top level of the rectangle collision table: controller plus datapath.
// Depends on aabb_pkg, aabb_ctrl, aabb_dpath (and aabb_ram below it).
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid/s_tready    s_tdata: one operation beat
//  m_       out        m_tvalid/m_tready    m_tdata + m_tlast: one result beat
//  cfg_     in         cfg_wr_en only       cfg_index, cfg_wdata: mask write
//
// Add, erase, purge, clear and unused action codes pass the execute state
// only, as does a sweep from a free or out-of-range slot. A sweep from slot i
// reads its base, compares each slot above i and adds a state per second hit
// direction; the single RAM read port sets one slot a cycle unless a hit waits.
// Synchronous active-low reset clears the slot flags and both valid bits and
// reloads the reset masks.
// A stalled output holds the block only when a new result must be loaded;
// one finished result may wait while the next beat is accepted.
module aabb_collision_table
    import aabb_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // action[2:0], slot[7:3], x_pos[23:8], y_pos[39:24], width[54:40],
    // height[69:55], kind[73:70], notify[74], zero[79:75]
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // status[1:0], receiver[6:2], other[11:7], zero[15:12]
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tlast,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [MASK_W-1:0]       cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    aabb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    aabb_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sim/aabb_table_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the rectangle collision table: watches the operation, result
// and mask-write ports, predicts every result beat and compares in order.
// Depends on aabb_pkg for widths, the action codes and the status codes.
module aabb_table_checker
    import aabb_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MASK_W-1:0]      cfg_wdata,
    output int                     mismatches,
    output int                     replies_waiting,
    output int                     reply_beats,
    output int                     hit_pairs,
    output int                     full_answers
);

    localparam int REPORT_LIMIT = 10;

    // Receive masks after reset, wall first
    localparam logic [MASK_W-1:0] MASK_AFTER_RESET [NUM_MASKS] =
        '{8'd2, 8'd205, 8'd2, 8'd2, 8'd141, 8'd205, 8'd21, 8'd0};

    // One operation beat as it sits in s_tdata, highest field first
    typedef struct packed {
        logic [4:0]          pad;
        logic                notify;
        logic [KIND_W-1:0]   kind;
        logic [14:0]         h;
        logic [14:0]         w;
        logic signed [15:0]  y;
        logic signed [15:0]  x;
        logic [SLOT_FW-1:0]  slot;
        logic [2:0]          action;
    } table_op_t;

    typedef struct packed {
        res_status_t         status;
        logic [SLOT_FW-1:0]  receiver;
        logic [SLOT_FW-1:0]  other;
        logic                last;
    } table_reply_t;

    logic [MASK_W-1:0] recv_mask [NUM_MASKS];
    logic [SLOTS-1:0]  occupied;
    logic [SLOTS-1:0]  doomed;
    rect_rec_t         entry [SLOTS];
    table_reply_t      replies_due [$];
    table_reply_t      want;
    table_reply_t      got;
    int                errs;
    int                beats;
    int                hits;
    int                fulls;

    function automatic table_reply_t reply(res_status_t st, int rc, int ot);
        return '{status: st, receiver: SLOT_FW'(rc), other: SLOT_FW'(ot), last: 1'b0};
    endfunction

    // Strict overlap, edges summed in 32 bits so nothing wraps
    function automatic bit boxes_overlap(rect_rec_t a, rect_rec_t b);
        int ax;
        int ay;
        int bx;
        int by;
        ax = a.x;
        ay = a.y;
        bx = b.x;
        by = b.y;
        return ax < bx + int'(b.w) && ax + int'(a.w) > bx &&
               ay < by + int'(b.h) && ay + int'(a.h) > by;
    endfunction

    // Slot r is told about slot o
    function automatic bit takes_hit(int r, int o);
        int kr;
        int ko;
        kr = entry[r].kind;
        ko = entry[o].kind;
        if (!entry[r].notify)
            return 1'b0;
        if (kr < 1 || kr > NUM_MASKS || ko < 1 || ko > NUM_MASKS)
            return 1'b0;
        return recv_mask[kr - 1][ko - 1];
    endfunction

    // Apply one operation to the shadow table and queue its results
    task automatic predict_op(table_op_t op);
        table_reply_t fresh [$];
        table_reply_t tail;
        int           free_slot;
        int           i;
        int           k;
        int           s;
        s = op.slot;
        case (op.action)
            ACT_ADD: begin
                free_slot = -1;
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!occupied[i])
                        free_slot = i;
                if (free_slot >= 0) begin
                    occupied[free_slot] = 1'b1;
                    doomed[free_slot]   = 1'b0;
                    entry[free_slot]    = '{x: op.x, y: op.y, w: op.w, h: op.h,
                                            kind: op.kind, notify: op.notify};
                    fresh.push_back(reply(RES_ADDED, free_slot, 0));
                end else begin
                    fresh.push_back(reply(RES_FULL, 0, 0));
                end
            end
            ACT_ERASE: begin
                if (s < SLOTS && occupied[s])
                    doomed[s] = 1'b1;
                fresh.push_back(reply(RES_DONE, 0, 0));
            end
            ACT_PURGE: begin
                occupied = occupied & ~doomed;
                doomed   = '0;
                fresh.push_back(reply(RES_DONE, 0, 0));
            end
            ACT_SWEEP: begin
                if (s < SLOTS && occupied[s]) begin
                    for (k = s + 1; k < SLOTS; k++) begin
                        if (occupied[k] && boxes_overlap(entry[s], entry[k])) begin
                            if (takes_hit(s, k))
                                fresh.push_back(reply(RES_HIT, s, k));
                            if (takes_hit(k, s))
                                fresh.push_back(reply(RES_HIT, k, s));
                        end
                    end
                end
                if (fresh.size() == 0)
                    fresh.push_back(reply(RES_DONE, 0, 0));
            end
            ACT_CLEAR: begin
                occupied = '0;
                doomed   = '0;
                fresh.push_back(reply(RES_DONE, 0, 0));
            end
            default: begin
                fresh.push_back(reply(RES_DONE, 0, 0));
            end
        endcase
        // Mark the final beat of the operation
        tail = fresh.pop_back();
        tail.last = 1'b1;
        fresh.push_back(tail);
        foreach (fresh[i])
            replies_due.push_back(fresh[i]);
    endtask

    function automatic void note_fault(bit have_want, table_reply_t exp_r, table_reply_t act_r);
        errs++;
        if (errs <= REPORT_LIMIT) begin
            if (have_want)
                $display("[%0t] mismatch: expected status %0d recv %0d other %0d last %0b, got status %0d recv %0d other %0d last %0b",
                         $time, exp_r.status, exp_r.receiver, exp_r.other, exp_r.last,
                         act_r.status, act_r.receiver, act_r.other, act_r.last);
            else
                $display("[%0t] mismatch: result beat with nothing due, got status %0d recv %0d other %0d last %0b",
                         $time, act_r.status, act_r.receiver, act_r.other, act_r.last);
        end
    endfunction

    // Track mask writes and operations, then check the result beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (recv_mask[i])
                recv_mask[i] = MASK_AFTER_RESET[i];
            occupied = '0;
            doomed   = '0;
            replies_due.delete();
            errs  = 0;
            beats = 0;
            hits  = 0;
            fulls = 0;
        end else begin
            if (cfg_wr_en)
                recv_mask[cfg_index] = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_op(table_op_t'(s_tdata));
            if (m_tvalid && m_tready) begin
                got = '{status: res_status_t'(m_tdata[1:0]), receiver: m_tdata[6:2],
                        other: m_tdata[11:7], last: m_tlast};
                beats++;
                if (got.status == RES_HIT)
                    hits++;
                if (got.status == RES_FULL)
                    fulls++;
                if (replies_due.size() == 0) begin
                    note_fault(1'b0, got, got);
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want)
                        note_fault(1'b1, want, got);
                end
            end
        end
        mismatches      <= errs;
        replies_waiting <= replies_due.size();
        reply_beats     <= beats;
        hit_pairs       <= hits;
        full_answers    <= fulls;
    end

endmodule

// ===== sim/aabb_collision_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the rectangle collision table: drives operation beats, mask
// writes and result back-pressure, and gives the verdict from aabb_table_checker.
// Depends on aabb_pkg, aabb_collision_table and aabb_table_checker.
module aabb_collision_table_tb;
    import aabb_pkg::*;

    localparam int SLOTS        = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
    // Mixed episodes rarely hold more entries than this
    localparam int BUSY_SLOTS   = 12;

    localparam logic [KIND_W-1:0] KIND_NONE   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_WALL   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PLAYER = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DEATH  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_GOD    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_ENEMY  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_COIN   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_BOGUS  = 4'd15;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [MASK_W-1:0]      cfg_wdata = '0;

    int mismatches;
    int replies_waiting;
    int reply_beats;
    int hit_pairs;
    int full_answers;
    int ops_sent    = 0;
    int mask_loads  = 0;
    int cycle_count = 0;
    bit calm_flow   = 1'b0;
    bit hold_req    = 1'b0;

    aabb_collision_table #(
        .SLOTS    (SLOTS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    aabb_table_checker #(
        .SLOTS          (SLOTS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .replies_waiting(replies_waiting),
        .reply_beats    (reply_beats),
        .hit_pairs      (hit_pairs),
        .full_answers   (full_answers)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // End the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic int draw_pause();
        return calm_flow ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [IN_TDATA_W-1:0] op_beat(logic [2:0] action,
                                                      logic [SLOT_FW-1:0] slot,
                                                      logic signed [15:0] x,
                                                      logic signed [15:0] y,
                                                      logic [14:0] w, logic [14:0] h,
                                                      logic [KIND_W-1:0] kind,
                                                      logic notify);
        return IN_TDATA_W'({notify, kind, h, w, y, x, slot, action});
    endfunction

    function automatic logic [SLOT_FW-1:0] pick_slot();
        if ($urandom_range(0, 3) == 0)
            return SLOT_FW'($urandom_range(0, SLOTS - 1));
        return SLOT_FW'($urandom_range(0, BUSY_SLOTS - 1));
    endfunction

    function automatic mask_bank_t random_masks();
        mask_bank_t bank;
        int         idx;
        for (idx = 0; idx < NUM_MASKS; idx++)
            bank[idx] = MASK_W'($urandom);
        return bank;
    endfunction

    // Offer one beat after a random gap; valid stays high when the gap is zero
    task automatic send_beat(logic [IN_TDATA_W-1:0] beat);
        int gap;
        gap = draw_pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        ops_sent++;
    endtask

    // Non-add operation, unused fields filled with noise
    task automatic issue(logic [2:0] action, logic [SLOT_FW-1:0] slot);
        send_beat(op_beat(action, slot, 16'($urandom), 16'($urandom), 15'($urandom),
                          15'($urandom), KIND_W'($urandom), 1'($urandom)));
    endtask

    task automatic place(logic signed [15:0] x, logic signed [15:0] y, logic [14:0] w,
                         logic [14:0] h, logic [KIND_W-1:0] kind, logic notify);
        send_beat(op_beat(ACT_ADD, SLOT_FW'($urandom), x, y, w, h, kind, notify));
    endtask

    // Mostly small boxes near the origin so they overlap, sometimes anywhere
    task automatic place_random();
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [KIND_W-1:0]  kind;
        if ($urandom_range(0, 7) == 0) begin
            x = 16'($urandom);
            y = 16'($urandom);
            w = 15'($urandom);
            h = 15'($urandom);
        end else begin
            x = 16'(int'($urandom_range(0, 200)) - 100);
            y = 16'(int'($urandom_range(0, 200)) - 100);
            w = 15'($urandom_range(0, 80));
            h = 15'($urandom_range(0, 80));
        end
        if ($urandom_range(0, 9) == 0)
            kind = KIND_W'($urandom);
        else
            kind = KIND_W'($urandom_range(KIND_WALL, KIND_COIN));
        place(x, y, w, h, kind, $urandom_range(0, 5) != 0);
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_waiting != 0);
    endtask

    task automatic load_masks(mask_bank_t bank);
        int idx;
        for (idx = 0; idx < NUM_MASKS; idx++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(idx);
            cfg_wdata <= bank[idx];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        mask_loads++;
    endtask

    // Edge cases under the reset masks
    task automatic run_directed();
        issue(ACT_SWEEP, 5'd0);
        issue(ACT_ERASE, 5'd31);
        issue(ACT_PURGE, 5'd0);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            issue(3'(a), SLOT_FW'($urandom));
        place(16'sd0, 16'sd0, 15'd10, 15'd10, KIND_PLAYER, 1'b1);
        place(16'sd5, 16'sd5, 15'd10, 15'd10, KIND_WALL, 1'b1);
        // touches the first box on its right edge only
        place(16'sd10, 16'sd0, 15'd5, 15'd5, KIND_COIN, 1'b1);
        place(16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF, KIND_ENEMY, 1'b1);
        place(16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF, KIND_GOD, 1'b1);
        place(-16'sd20, -16'sd20, 15'd100, 15'd100, KIND_BOGUS, 1'b1);
        place(-16'sd20, -16'sd20, 15'd100, 15'd100, KIND_NONE, 1'b1);
        place(16'sd0, 16'sd0, 15'h7FFF, 15'h7FFF, KIND_PLAYER, 1'b0);
        place(16'sd3, 16'sd3, 15'd0, 15'd0, KIND_PLAYER, 1'b1);
        issue(ACT_SWEEP, 5'd0);
        issue(ACT_SWEEP, 5'd1);
        issue(ACT_SWEEP, 5'd3);
        issue(ACT_SWEEP, 5'd31);
        // a marked slot still collides until purged
        issue(ACT_ERASE, 5'd1);
        issue(ACT_SWEEP, 5'd0);
        issue(ACT_PURGE, SLOT_FW'($urandom));
        issue(ACT_SWEEP, 5'd0);
        place(16'sd2, 16'sd2, 15'd4, 15'd4, KIND_DEATH, 1'b1);
        issue(ACT_SWEEP, 5'd0);
        issue(ACT_CLEAR, SLOT_FW'($urandom));
        issue(ACT_SWEEP, 5'd0);
    endtask

    task automatic run_mixed_ops(int count);
        int j;
        int pick;
        for (j = 0; j < count; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                place_random();
            else if (pick < 70)
                issue(ACT_SWEEP, pick_slot());
            else if (pick < 84)
                issue(ACT_ERASE, pick_slot());
            else if (pick < 91)
                issue(ACT_PURGE, pick_slot());
            else if (pick < 95)
                issue(ACT_CLEAR, pick_slot());
            else
                issue(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), pick_slot());
        end
    endtask

    // Fill the table with boxes that all overlap, overflow it, and sweep
    // while the result side holds off
    task automatic crowd_table();
        int j;
        issue(ACT_CLEAR, SLOT_FW'($urandom));
        for (j = 0; j < SLOTS; j++)
            place(16'(int'($urandom_range(0, 40)) - 20), 16'(int'($urandom_range(0, 40)) - 20),
                  15'($urandom_range(100, 300)), 15'($urandom_range(100, 300)),
                  KIND_WALL + KIND_W'(j % NUM_MASKS), 1'b1);
        place_random();
        hold_req = 1'b1;
        issue(ACT_SWEEP, 5'd0);
        for (j = 0; j < 4; j++)
            issue(ACT_SWEEP, SLOT_FW'($urandom));
        for (j = 0; j < 3; j++)
            issue(ACT_ERASE, SLOT_FW'($urandom));
        issue(ACT_PURGE, SLOT_FW'($urandom));
        for (j = 0; j < 3; j++)
            place_random();
        issue(ACT_SWEEP, 5'd0);
    endtask

    // Result side: random stall per beat, one long hold on request
    initial begin
        int pause;
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            pause = draw_pause();
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        settle();

        load_masks('1);
        calm_flow = 1'b1;
        run_mixed_ops(15);
        settle();
        calm_flow = 1'b0;

        load_masks('0);
        run_mixed_ops(8);
        settle();

        load_masks('1);
        crowd_table();
        settle();

        load_masks(random_masks());
        run_mixed_ops(12);
        settle();

        load_masks(random_masks());
        run_mixed_ops(12);
        settle();

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d operations over %0d mask sets, a full table, a long stall",
                 ops_sent, mask_loads + 1);
        $display("checked %0d result beats: %0d hit pairs, %0d table-full answers, %0d mismatches",
                 reply_beats, hit_pairs, full_answers, mismatches);
        if (mismatches == 0 && replies_waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== aabb_collision_table.f =====
rtl/core/aabb_pkg.sv
rtl/core/aabb_ram.sv
rtl/core/aabb_ctrl.sv
rtl/core/aabb_dpath.sv
rtl/core/aabb_collision_table.sv
sim/aabb_table_checker.sv
sim/aabb_collision_table_tb.sv
